FILE: hw/rtl/zmachine_table_memory_unit_defines.svh
// assertion macros for the memory and table unit checks
`ifndef ZMACHINE_TABLE_MEMORY_UNIT_DEFINES_SVH
`define ZMACHINE_TABLE_MEMORY_UNIT_DEFINES_SVH

// same-cycle implication, ignored while in reset
`define ZMTM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("zmtm check failed");

// next-cycle implication, ignored while in reset
`define ZMTM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("zmtm check failed");

// next-cycle implication that also covers reset
`define ZMTM_ASSERT_RST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) (ante) |=> (cons)) \
    else $error("zmtm reset check failed");

`endif

FILE: hw/rtl/zmtm_pkg.sv
// shared types and constants of the memory and table unit
package zmtm_pkg;

  localparam int unsigned MEM_BYTES    = 65536;
  localparam int unsigned MEM_AW       = $clog2(MEM_BYTES);
  localparam int unsigned HEADER_LIMIT = 64;

  localparam logic [7:0]  DEFAULT_FORM  = 8'h82;
  localparam logic [15:0] FLAGS2_ADDR   = 16'h0011;
  localparam logic [7:0]  DYNAMIC_BITS  = 8'h07;

  // request type codes
  localparam logic [2:0] REQ_LOAD_BYTE  = 3'd0;
  localparam logic [2:0] REQ_LOAD_WORD  = 3'd1;
  localparam logic [2:0] REQ_STORE_BYTE = 3'd2;
  localparam logic [2:0] REQ_STORE_WORD = 3'd3;
  localparam logic [2:0] REQ_COPY       = 3'd4;
  localparam logic [2:0] REQ_SCAN       = 3'd5;
  localparam logic [2:0] REQ_FILL       = 3'd6;

  // transcript and fixed-pitch change codes
  localparam logic [1:0] CHG_NONE = 2'd0;
  localparam logic [1:0] CHG_ON   = 2'd1;
  localparam logic [1:0] CHG_OFF  = 2'd2;

  // header error bits
  localparam logic [1:0] ERR_HDR_BYTE = 2'b01;
  localparam logic [1:0] ERR_FLAGS2   = 2'b10;

  typedef enum logic [3:0] {
    OP_LDB,
    OP_LDW,
    OP_STB,
    OP_STW,
    OP_COPY,
    OP_ZERO,
    OP_SCAN,
    OP_FILL,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] addr;    // effective address, copy source or scan start
    logic [15:0] dst;     // copy destination
    logic [15:0] val;     // store value, fill byte or search value
    logic [15:0] count;   // copy size or scan entry count
    logic [6:0]  stride;
    logic        word;    // word compare in scan
    logic        back;    // backward copy
    logic        hdr;     // word store starts in the header
  } cmd_t;

  typedef struct packed {
    logic [15:0] result;
    logic        branch;
    logic [1:0]  err;
    logic [1:0]  trans;
    logic [1:0]  fixp;
  } rsp_t;

endpackage

FILE: hw/rtl/zmtm_ram.sv
// generic single-write, single-read ram with registered read
module zmtm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hw/rtl/zmtm_front.sv
// request decode and two-entry command queue
module zmtm_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  logic [2:0]    req_type_i,
  input  logic [15:0]   first_operand_i,
  input  logic [15:0]   second_operand_i,
  input  logic [15:0]   third_operand_i,
  input  logic [7:0]    scan_form_i,
  input  logic          form_given_i,
  output logic          cmd_valid_o,
  output zmtm_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);
  import zmtm_pkg::*;

  cmd_t        cmd;
  cmd_t        q_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic [15:0] a, b, c, size, eff_b, eff_w;
  logic [7:0]  form;
  logic        push_ok, pop_ok;

  assign a = first_operand_i;
  assign b = second_operand_i;
  assign c = third_operand_i;
  assign eff_b = a + b;
  assign eff_w = a + {b[14:0], 1'b0};
  assign form  = form_given_i ? scan_form_i : DEFAULT_FORM;
  assign size  = c[15] ? (~c + 16'd1) : c;

  always_comb begin
    cmd        = '0;
    cmd.op     = OP_NOP;
    cmd.val    = c;
    cmd.stride = form[6:0];
    cmd.word   = form[7];
    unique case (req_type_i)
      REQ_LOAD_BYTE: begin
        cmd.op   = OP_LDB;
        cmd.addr = eff_b;
      end
      REQ_LOAD_WORD: begin
        cmd.op   = OP_LDW;
        cmd.addr = eff_w;
      end
      REQ_STORE_BYTE: begin
        cmd.op   = OP_STB;
        cmd.addr = eff_b;
      end
      REQ_STORE_WORD: begin
        cmd.op   = OP_STW;
        cmd.addr = eff_w;
        cmd.hdr  = eff_w < 16'(HEADER_LIMIT);
      end
      REQ_COPY: begin
        cmd.count = size;
        if (b == 16'd0) begin
          cmd.op   = OP_ZERO;
          cmd.addr = a;
        end else if (a > b || c[15]) begin
          cmd.op   = OP_COPY;
          cmd.addr = a;
          cmd.dst  = b;
        end else begin
          // backward copy starts at the last byte
          cmd.op   = OP_COPY;
          cmd.back = 1'b1;
          cmd.addr = a + c + 16'hFFFF;
          cmd.dst  = b + c + 16'hFFFF;
        end
      end
      REQ_SCAN: begin
        cmd.op    = OP_SCAN;
        cmd.addr  = b;
        cmd.val   = a;
        cmd.count = c;
      end
      REQ_FILL: begin
        cmd.op   = OP_FILL;
        cmd.addr = a;
      end
      default: cmd.op = OP_NOP;
    endcase
  end

  assign full_o      = cnt_q == 2'd2;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o       = q_q[rd_q];
  assign push_ok     = push_i && !full_o;
  assign pop_ok      = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      q_q[wr_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_ok) wr_q <= ~wr_q;
      if (pop_ok)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_ok} - {1'b0, pop_ok};
    end
  end

endmodule

FILE: hw/rtl/zmtm_back.sv
// execution sequencer over the byte memory
module zmtm_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  input  zmtm_pkg::cmd_t               cmd_i,
  output logic                         cmd_pop_o,
  output logic                         rsp_valid_o,
  output zmtm_pkg::rsp_t               rsp_o,
  input  logic                         rsp_ready_i,
  output logic                         ram_we_o,
  output logic [zmtm_pkg::MEM_AW-1:0]  ram_waddr_o,
  output logic [7:0]                   ram_wdata_o,
  output logic [zmtm_pkg::MEM_AW-1:0]  ram_raddr_o,
  input  logic [7:0]                   ram_rdata_i
);
  import zmtm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LD_HI, S_LD_LO, S_PROT, S_STW_LO, S_ZERO,
    S_COPY, S_SCAN, S_SCAN_LO, S_DONE
  } state_e;

  state_e      state_q, state_d;
  cmd_t        cur_q, cur_d;
  rsp_t        rsp_q, rsp_d;
  logic        phase_q, phase_d;
  logic [7:0]  hi_q, hi_d;
  logic        byp_q;
  logic [7:0]  bypd_q;
  logic [7:0]  rd, v, diff;
  logic [15:0] raddr, waddr, step, nxt;
  logic        we, match;
  logic [7:0]  wdata;

  assign rd   = byp_q ? bypd_q : ram_rdata_i;
  assign step = cur_q.back ? 16'hFFFF : 16'h0001;
  assign nxt  = cur_q.addr + {9'd0, cur_q.stride};

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    rsp_d     = rsp_q;
    phase_d   = phase_q;
    hi_d      = hi_q;
    raddr     = cur_q.addr;
    waddr     = cur_q.addr;
    wdata     = 8'd0;
    we        = 1'b0;
    cmd_pop_o = 1'b0;
    v         = 8'd0;
    diff      = 8'd0;
    match     = 1'b0;
    unique case (state_q) inside
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          rsp_d     = '0;
          phase_d   = 1'b0;
          raddr     = cmd_i.addr;
          waddr     = cmd_i.addr;
          unique case (cmd_i.op)
            OP_LDB:  state_d = S_LD_LO;
            OP_LDW:  state_d = S_LD_HI;
            OP_STB:  state_d = S_PROT;
            OP_STW: begin
              if (cmd_i.hdr) begin
                state_d = S_PROT;
              end else begin
                we      = 1'b1;
                wdata   = cmd_i.val[15:8];
                state_d = S_STW_LO;
              end
            end
            OP_ZERO: state_d = (cmd_i.count == 16'd0) ? S_DONE : S_ZERO;
            OP_COPY: state_d = (cmd_i.count == 16'd0) ? S_DONE : S_COPY;
            OP_SCAN: state_d = (cmd_i.count == 16'd0) ? S_DONE : S_SCAN;
            OP_FILL: begin
              we      = 1'b1;
              wdata   = cmd_i.val[7:0];
              state_d = S_DONE;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_LD_HI: begin
        hi_d    = rd;
        raddr   = cur_q.addr + 16'd1;
        state_d = S_LD_LO;
      end
      S_LD_LO: begin
        rsp_d.result = (cur_q.op == OP_LDW) ? {hi_q, rd} : {8'd0, rd};
        state_d      = S_DONE;
      end
      S_PROT: begin
        v    = (cur_q.op == OP_STW && !phase_q) ? cur_q.val[15:8] : cur_q.val[7:0];
        diff = rd ^ v;
        wdata = v;
        if (diff != 8'd0) begin
          if (cur_q.addr >= 16'(HEADER_LIMIT)) begin
            we = 1'b1;
          end else if (cur_q.addr != FLAGS2_ADDR) begin
            rsp_d.err = rsp_q.err | ERR_HDR_BYTE;
          end else if (diff > DYNAMIC_BITS) begin
            rsp_d.err = rsp_q.err | ERR_FLAGS2;
          end else begin
            we = 1'b1;
            if (diff[0]) rsp_d.trans = v[0] ? CHG_ON : CHG_OFF;
            if (diff[1]) rsp_d.fixp  = v[1] ? CHG_ON : CHG_OFF;
          end
        end
        if (cur_q.op == OP_STW && !phase_q) begin
          phase_d    = 1'b1;
          cur_d.addr = cur_q.addr + 16'd1;
          raddr      = cur_q.addr + 16'd1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_STW_LO: begin
        we      = 1'b1;
        waddr   = cur_q.addr + 16'd1;
        wdata   = cur_q.val[7:0];
        state_d = S_DONE;
      end
      S_ZERO: begin
        we          = 1'b1;
        cur_d.addr  = cur_q.addr + 16'd1;
        cur_d.count = cur_q.count - 16'd1;
        if (cur_q.count == 16'd1) state_d = S_DONE;
      end
      S_COPY: begin
        // write this byte while the next source byte is read
        we          = 1'b1;
        waddr       = cur_q.dst;
        wdata       = rd;
        raddr       = cur_q.addr + step;
        cur_d.addr  = cur_q.addr + step;
        cur_d.dst   = cur_q.dst + step;
        cur_d.count = cur_q.count - 16'd1;
        if (cur_q.count == 16'd1) state_d = S_DONE;
      end
      S_SCAN, S_SCAN_LO: begin
        if (state_q == S_SCAN && cur_q.word) begin
          hi_d    = rd;
          raddr   = cur_q.addr + 16'd1;
          state_d = S_SCAN_LO;
        end else begin
          if (state_q == S_SCAN_LO) begin
            match = {hi_q, rd} == cur_q.val;
          end else begin
            match = (cur_q.val[15:8] == 8'd0) && (rd == cur_q.val[7:0]);
          end
          if (match) begin
            rsp_d.result = cur_q.addr;
            rsp_d.branch = 1'b1;
            state_d      = S_DONE;
          end else if (cur_q.count == 16'd1) begin
            state_d = S_DONE;
          end else begin
            cur_d.addr  = nxt;
            cur_d.count = cur_q.count - 16'd1;
            raddr       = nxt;
            state_d     = S_SCAN;
          end
        end
      end
      S_DONE: begin
        if (rsp_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign ram_we_o    = we;
  assign ram_waddr_o = waddr[MEM_AW-1:0];
  assign ram_wdata_o = wdata;
  assign ram_raddr_o = raddr[MEM_AW-1:0];
  assign rsp_valid_o = state_q == S_DONE;
  assign rsp_o       = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      byp_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      // the ram returns old data when read and write meet
      byp_q   <= we && (waddr[MEM_AW-1:0] == raddr[MEM_AW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    rsp_q   <= rsp_d;
    phase_q <= phase_d;
    hi_q    <= hi_d;
    bypd_q  <= wdata;
  end

endmodule

FILE: hw/rtl/zmachine_table_memory_unit.sv
// top level of the memory and table unit
//
//  channel   direction  handshake   transaction
//  request   in         push/full   req_type_i, operands, scan_form_i, form_given_i
//  result    out        pop/empty   result_value_o, branch_taken_o, change and error codes
//
//  loads and byte or header word stores read memory first, fill writes at once, and each
//  ends in a step that hands the result over; copy and zero handle one byte per step, and
//  scan reads each entry, a word entry as two bytes; all set by the single ram read port
//  reset clears the command queue, the sequencer and the result register;
//  memory contents are undefined until written, no clearing pass
//  a full command queue drops full low only when the sequencer takes a command;
//  a waiting result holds the sequencer in its hand-over step
module zmachine_table_memory_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  req_type_i,
  input  logic [15:0] first_operand_i,
  input  logic [15:0] second_operand_i,
  input  logic [15:0] third_operand_i,
  input  logic [7:0]  scan_form_i,
  input  logic        form_given_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] result_value_o,
  output logic        branch_taken_o,
  output logic [1:0]  header_error_o,
  output logic [1:0]  transcript_change_o,
  output logic [1:0]  fixed_pitch_change_o
);
  import zmtm_pkg::*;

  cmd_t              cmd;
  rsp_t              rsp, out_q;
  logic              cmd_valid, cmd_pop;
  logic              rsp_valid, rsp_ready;
  logic              out_valid_q;
  logic              ram_we;
  logic [MEM_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  // front end: decode and queue requests
  zmtm_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .full_o           (full),
    .req_type_i       (req_type_i),
    .first_operand_i  (first_operand_i),
    .second_operand_i (second_operand_i),
    .third_operand_i  (third_operand_i),
    .scan_form_i      (scan_form_i),
    .form_given_i     (form_given_i),
    .cmd_valid_o      (cmd_valid),
    .cmd_o            (cmd),
    .cmd_pop_i        (cmd_pop)
  );

  // back end: sequencer over the memory
  zmtm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp),
    .rsp_ready_i (rsp_ready),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // byte memory of the machine
  zmtm_ram #(
    .Width (8),
    .Depth (MEM_BYTES)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // result register: free when empty or being popped this cycle
  assign rsp_ready = !out_valid_q || pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_valid && rsp_ready) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_valid && rsp_ready) begin
      out_q <= rsp;
    end
  end

  assign empty                = !out_valid_q;
  assign result_value_o       = out_q.result;
  assign branch_taken_o       = out_q.branch;
  assign header_error_o       = out_q.err;
  assign transcript_change_o  = out_q.trans;
  assign fixed_pitch_change_o = out_q.fixp;

endmodule

FILE: hw/rtl/zmtm_checker.sv
// port-level checks of the memory and table unit and their binding
`include "zmachine_table_memory_unit_defines.svh"

module zmtm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic [2:0]  req_type_i,
  input logic [15:0] first_operand_i,
  input logic [15:0] second_operand_i,
  input logic [15:0] third_operand_i,
  input logic [7:0]  scan_form_i,
  input logic        form_given_i,
  input logic        empty,
  input logic        pop,
  input logic [15:0] result_value_o,
  input logic        branch_taken_o,
  input logic [1:0]  header_error_o,
  input logic [1:0]  transcript_change_o,
  input logic [1:0]  fixed_pitch_change_o
);
  import zmtm_pkg::*;

  // a waiting result stays until popped
  `ZMTM_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(result_value_o))
  // a scan hit carries no store reports
  `ZMTM_ASSERT_IMPL(a_hit_clean, !empty && branch_taken_o, header_error_o == 2'b00 && transcript_change_o == CHG_NONE && fixed_pitch_change_o == CHG_NONE)
  // change codes are only none, on or off
  `ZMTM_ASSERT_IMPL(a_change_codes, !empty, transcript_change_o != 2'd3 && fixed_pitch_change_o != 2'd3)
  // nothing waits right after reset
  `ZMTM_ASSERT_RST_NEXT(a_reset_empty, !rst_ni, empty)

endmodule

bind zmachine_table_memory_unit zmtm_checker u_zmtm_checker (.*);

FILE: tb/zmachine_table_memory_unit_checker.sv
// checker: predicts every result of the memory and table unit and compares it
`timescale 1ns / 100ps
module zmachine_table_memory_unit_checker
  import zmtm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [2:0]  req_type_i,
  input  logic [15:0] first_operand_i,
  input  logic [15:0] second_operand_i,
  input  logic [15:0] third_operand_i,
  input  logic [7:0]  scan_form_i,
  input  logic        form_given_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [15:0] result_value_i,
  input  logic        branch_taken_i,
  input  logic [1:0]  header_error_i,
  input  logic [1:0]  transcript_change_i,
  input  logic [1:0]  fixed_pitch_change_i,
  output int          pending_o,
  output int          errors_o
);

  logic [7:0] story_mem [MEM_BYTES];
  rsp_t       rsp_q [$];

  // header-protected byte store
  task automatic guarded_store(input logic [15:0] addr, input logic [7:0] v,
                               inout rsp_t r);
    logic [7:0] diff;
    diff = story_mem[addr] ^ v;
    if (diff == 8'h00) return;
    if (addr >= HEADER_LIMIT) begin
      story_mem[addr] = v;
    end else if (addr != FLAGS2_ADDR) begin
      r.err |= ERR_HDR_BYTE;
    end else if (diff > DYNAMIC_BITS) begin
      r.err |= ERR_FLAGS2;
    end else begin
      story_mem[addr] = v;
      if (diff[0]) r.trans = v[0] ? CHG_ON : CHG_OFF;
      if (diff[1]) r.fixp  = v[1] ? CHG_ON : CHG_OFF;
    end
  endtask

  task automatic run_request(input logic [2:0] kind, input logic [15:0] a,
                             input logic [15:0] b, input logic [15:0] c,
                             input logic [7:0] form, output rsp_t r);
    logic [15:0] addr, cur;
    logic [16:0] size;
    r = '0;
    case (kind)
      REQ_LOAD_BYTE: begin
        addr = a + b;
        r.result = {8'h00, story_mem[addr]};
      end
      REQ_LOAD_WORD: begin
        addr = a + 16'(2 * b);
        r.result = {story_mem[addr], story_mem[16'(addr + 1)]};
      end
      REQ_STORE_BYTE: guarded_store(a + b, c[7:0], r);
      REQ_STORE_WORD: begin
        addr = a + 16'(2 * b);
        if (addr < HEADER_LIMIT) begin
          guarded_store(addr, c[15:8], r);
          guarded_store(addr + 16'd1, c[7:0], r);
        end else begin
          story_mem[addr] = c[15:8];
          story_mem[16'(addr + 1)] = c[7:0];
        end
      end
      REQ_COPY: begin
        size = c[15] ? 17'(16'(17'h10000 - c)) : 17'(c);
        if (c == 16'h8000) size = 17'h8000;
        if (b == 16'd0) begin
          for (int i = 0; i < size; i++) story_mem[16'(a + i)] = 8'h00;
        end else if (a > b || c[15]) begin
          for (int i = 0; i < size; i++) story_mem[16'(b + i)] = story_mem[16'(a + i)];
        end else begin
          for (int i = 0; i < size; i++)
            story_mem[16'(b + size - i - 1)] = story_mem[16'(a + size - i - 1)];
        end
      end
      REQ_SCAN: begin
        cur = b;
        for (int i = 0; i < c; i++) begin
          if (form[7] ? ({story_mem[cur], story_mem[16'(cur + 1)]} == a)
                      : ({8'h00, story_mem[cur]} == a)) begin
            r.result = cur;
            r.branch = 1'b1;
            break;
          end
          cur = cur + 16'(form[6:0]);
        end
      end
      REQ_FILL: story_mem[a] = c[7:0];
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t r, want;
    int   bad;
    if (!rst_ni) begin
      rsp_q.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      bad = 0;
      if (push_i && !full_i) begin
        run_request(req_type_i, first_operand_i, second_operand_i, third_operand_i,
                    form_given_i ? scan_form_i : DEFAULT_FORM, r);
        rsp_q.push_back(r);
      end
      if (pop_i && !empty_i) begin
        if (rsp_q.size() == 0) begin
          $error("result transaction with nothing expected");
          bad++;
        end else begin
          want = rsp_q.pop_front();
          if (want.result != result_value_i) begin
            $error("result_value expected %h actual %h", want.result, result_value_i);
            bad++;
          end
          if (want.branch != branch_taken_i) begin
            $error("branch_taken expected %b actual %b", want.branch, branch_taken_i);
            bad++;
          end
          if (want.err != header_error_i) begin
            $error("header_error expected %h actual %h", want.err, header_error_i);
            bad++;
          end
          if (want.trans != transcript_change_i) begin
            $error("transcript_change expected %h actual %h", want.trans,
                   transcript_change_i);
            bad++;
          end
          if (want.fixp != fixed_pitch_change_i) begin
            $error("fixed_pitch_change expected %h actual %h", want.fixp,
                   fixed_pitch_change_i);
            bad++;
          end
        end
      end
      errors_o  <= errors_o + bad;
      pending_o <= rsp_q.size();
    end
  end

endmodule

FILE: tb/zmachine_table_memory_unit_tb.sv
// testbench top: stimulus, receiver stalls and verdict for the memory and table unit
`timescale 1ns / 100ps
module zmachine_table_memory_unit_tb;
  import zmtm_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int RANDOM_REQS = 1260;
  // every read lands in this window across the top of memory, which is filled first
  localparam logic [15:0] WIN_BASE  = 16'hff00;
  localparam int          WIN_BYTES = 512;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [2:0]  req_type_i = REQ_LOAD_BYTE;
  logic [15:0] first_operand_i = '0;
  logic [15:0] second_operand_i = '0;
  logic [15:0] third_operand_i = '0;
  logic [7:0]  scan_form_i = '0;
  logic        form_given_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [15:0] result_value_o;
  logic        branch_taken_o;
  logic [1:0]  header_error_o;
  logic [1:0]  transcript_change_o;
  logic [1:0]  fixed_pitch_change_o;

  int  pending, errors;
  int  cycles = 0;
  bit  hold_req = 1'b0;   // asks the receiver for one long hold-off
  int  burst_left = 0;

  always #1 clk_i = ~clk_i;

  zmachine_table_memory_unit dut (.*);

  zmachine_table_memory_unit_checker checker_i (
    .clk_i, .rst_ni,
    .push_i(push), .full_i(full),
    .req_type_i, .first_operand_i, .second_operand_i, .third_operand_i,
    .scan_form_i, .form_given_i,
    .empty_i(empty), .pop_i(pop),
    .result_value_i(result_value_o), .branch_taken_i(branch_taken_o),
    .header_error_i(header_error_o), .transcript_change_i(transcript_change_o),
    .fixed_pitch_change_i(fixed_pitch_change_o),
    .pending_o(pending), .errors_o(errors)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: picks a new stall pattern at the end of each random run, one long hold-off
  initial begin
    int mode, left, hold;
    bit held;
    mode = 0; left = 0; hold = 0; held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        hold = 400;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(50, 300);
      end
      left--;
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else begin
        case (mode)
          0: pop <= 1'b1;
          1: pop <= ($urandom_range(0, 1) == 1);
          2: pop <= ($urandom_range(0, 7) == 0);
          default: pop <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // one request transaction; push stays high through a burst
  task automatic send(input logic [2:0] kind, input logic [15:0] a, input logic [15:0] b,
                      input logic [15:0] c, input logic [7:0] form, input logic given,
                      input bit bursty);
    int gap;
    req_type_i       <= kind;
    first_operand_i  <= a;
    second_operand_i <= b;
    third_operand_i  <= c;
    scan_form_i      <= form;
    form_given_i     <= given;
    push             <= 1'b1;
    do @(posedge clk_i); while (full);
    if (bursty) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          push <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end else begin
        burst_left--;
      end
    end
  endtask

  // the pending count is registered, so the last accepted transaction shows in it only after its edge
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // start of a run of span bytes that lies wholly inside the window
  function automatic logic [15:0] pick_addr(input int span);
    int off;
    case ($urandom_range(0, 4))
      0: off = $urandom_range(16'h100, 16'h14f);   // header
      1: off = $urandom_range(16'hc0, 16'hff);     // just below the top
      2: off = $urandom_range(16'h10e, 16'h114);   // around flags2
      default: off = $urandom_range(0, WIN_BYTES - 1);
    endcase
    if (off > WIN_BYTES - span) off = WIN_BYTES - span;
    return WIN_BASE + 16'(off);
  endfunction

  initial begin
    logic [2:0]  kind;
    logic [15:0] a, b, c;
    logic [7:0]  form, eff;
    logic        given;
    int          span, step, most;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill the window so that every read is of written data
    for (int i = 0; i < WIN_BYTES; i++)
      send(REQ_FILL, WIN_BASE + 16'(i), 16'($urandom), 16'($urandom), 8'($urandom),
           1'($urandom), 0);

    // directed: extremes and corner cases
    send(REQ_FILL, FLAGS2_ADDR, 16'h0, 16'hff00, 8'h00, 1'b0, 0);
    send(REQ_STORE_BYTE, 16'h0010, 16'h0001, 16'h0003, 8'h00, 1'b0, 0);  // both bits on
    send(REQ_STORE_BYTE, 16'h0011, 16'h0000, 16'h0001, 8'h00, 1'b0, 0);  // fixed pitch off
    send(REQ_STORE_BYTE, 16'h0011, 16'h0000, 16'h0001, 8'h00, 1'b0, 0);  // equal value
    send(REQ_STORE_BYTE, 16'h0011, 16'h0000, 16'h0081, 8'h00, 1'b0, 0);  // upper bits
    send(REQ_STORE_BYTE, 16'h0005, 16'h0000, 16'hffff, 8'h00, 1'b0, 0);  // header byte
    send(REQ_STORE_WORD, 16'h0010, 16'h0000, 16'h5a02, 8'h00, 1'b0, 0);
    send(REQ_STORE_WORD, 16'h003f, 16'h0000, 16'hffff, 8'h00, 1'b0, 0);  // header edge
    send(REQ_STORE_WORD, 16'hffff, 16'h0000, 16'h1234, 8'h00, 1'b0, 0);  // top wrap
    send(REQ_STORE_WORD, 16'hfffe, 16'hffff, 16'h0000, 8'h00, 1'b0, 0);
    send(REQ_LOAD_WORD, 16'hffff, 16'h0000, 16'h0, 8'h00, 1'b0, 0);
    send(REQ_LOAD_BYTE, 16'hffff, 16'hffff, 16'h0, 8'h00, 1'b0, 0);
    send(REQ_LOAD_WORD, 16'h0000, 16'hffff, 16'h0, 8'hff, 1'b1, 0);
    send(REQ_COPY, 16'h0080, 16'h0084, 16'd20, 8'h00, 1'b0, 0);          // backward overlap
    send(REQ_COPY, 16'h0080, 16'h0084, 16'hfff0, 8'h00, 1'b0, 0);        // negative forward
    send(REQ_COPY, 16'h00a8, 16'h00a0, 16'd30, 8'h00, 1'b0, 0);          // source above
    send(REQ_COPY, 16'hfff8, 16'h0000, 16'hfff0, 8'h00, 1'b0, 0);        // zero, |size|
    send(REQ_COPY, 16'h4000, 16'h0000, 16'h8000, 8'h00, 1'b0, 0);        // largest zero
    send(REQ_SCAN, 16'h0000, 16'hfff0, 16'd40, 8'h01, 1'b1, 0);          // byte hit
    send(REQ_SCAN, 16'h0000, 16'hfff6, 16'd8, 8'h00, 1'b0, 0);           // default form
    send(REQ_SCAN, 16'h0100, 16'hfff8, 16'd8, 8'h01, 1'b1, 0);           // value above byte
    send(REQ_SCAN, 16'h0fff, 16'h0020, 16'hffff, 8'h00, 1'b1, 0);        // stride 0, long
    send(REQ_SCAN, 16'hffff, 16'hfff0, 16'd3, 8'h7f, 1'b1, 0);
    send(REQ_FILL, 16'hffff, 16'hffff, 16'hffff, 8'hff, 1'b1, 0);
    wait_drained();

    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n == 400) hold_req <= 1'b1;
      if (n == 800) wait_drained();
      kind  = 3'($urandom_range(0, 6));
      form  = 8'($urandom);
      given = 1'($urandom);
      a     = 16'($urandom);
      b     = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 8)) : 16'($urandom);
      c     = 16'($urandom);
      case (kind) inside
        REQ_LOAD_BYTE, REQ_STORE_BYTE: a = pick_addr(1) - b;
        REQ_LOAD_WORD, REQ_STORE_WORD: a = pick_addr(2) - {b[14:0], 1'b0};
        REQ_COPY: begin
          c    = 16'($urandom_range(0, 48));
          span = (c == 16'd0) ? 1 : int'(c);
          a    = pick_addr(span);
          if ($urandom_range(0, 2) == 0) c = -c;
          b    = ($urandom_range(0, 4) == 0) ? 16'h0 : pick_addr(span);
        end
        REQ_SCAN: begin
          eff  = given ? form : DEFAULT_FORM;
          step = int'(eff[6:0]);
          span = eff[7] ? 2 : 1;
          if ($urandom_range(0, 299) == 0) begin
            // long count over one spot
            given = 1'b1;
            form  = eff & 8'h80;
            b     = pick_addr(span);
          end else begin
            most = (step == 0) ? 48 : (WIN_BYTES - span) / step + 1;
            if (most > 48) most = 48;
            c = 16'($urandom_range(0, most));
            b = pick_addr((c == 16'd0) ? span : (int'(c) - 1) * step + span);
          end
          case ($urandom_range(0, 3))
            0: a = 16'h0;
            1: a = 16'($urandom_range(0, 255));
            default: ;
          endcase
        end
        REQ_FILL: a = pick_addr(1);
        default: ;
      endcase
      send(kind, a, b, c, form, given, 1);
    end

    wait_drained();
    repeat (100) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: zmachine_table_memory_unit.f
+incdir+hw/rtl
hw/rtl/zmtm_pkg.sv
hw/rtl/zmtm_ram.sv
hw/rtl/zmtm_front.sv
hw/rtl/zmtm_back.sv
hw/rtl/zmachine_table_memory_unit.sv
hw/rtl/zmtm_checker.sv
tb/zmachine_table_memory_unit_checker.sv
tb/zmachine_table_memory_unit_tb.sv
